// ===== rtl/core/mfq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mfq_pkg;

	localparam int NUM_SLOTS  = 64;
	localparam int NUM_LEVELS = 3;
	localparam int SLOT_W     = $clog2(NUM_SLOTS);
	localparam int LVL_W      = 2;
	localparam int RING_CNT   = NUM_LEVELS + 1;
	localparam int RING_W     = $clog2(RING_CNT);
	localparam int RADDR_W    = RING_W + SLOT_W;

	// slot status codes
	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_RUN     = 2'd2;
	localparam logic [1:0] ST_BLOCKED = 2'd3;

	// result status codes
	localparam logic [1:0] RES_OK       = 2'd0;
	localparam logic [1:0] RES_SAMEMODE = 2'd1;
	localparam logic [1:0] RES_BADPRIO  = 2'd2;
	localparam logic [1:0] RES_FULL     = 2'd3;

	// register indexes
	localparam logic [1:0] REG_LIM0   = 2'd0;
	localparam logic [1:0] REG_LIM1   = 2'd1;
	localparam logic [1:0] REG_LIM2   = 2'd2;
	localparam logic [1:0] REG_PERIOD = 2'd3;

	localparam logic [LVL_W-1:0] LEVEL_FCFS = 2'd3;
	localparam logic [1:0]       PRIO_TOP   = 2'd3;

	typedef enum logic [2:0] {
		OP_READY    = 3'd0,
		OP_BLOCK    = 3'd1,
		OP_DISPATCH = 3'd2,
		OP_RUNDONE  = 3'd3,
		OP_TICK     = 3'd4,
		OP_MODE     = 3'd5,
		OP_SETPRIO  = 3'd6,
		OP_NOP      = 3'd7
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [5:0]  slot;
		logic [7:0]  quanta_used;
		logic        still_runnable;
		logic        new_mode;
		logic [3:0]  priority_value;
	} item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [LVL_W-1:0] level;
		logic [1:0]       prio;
		logic [7:0]       quanta;
	} slot_info_t;

	typedef struct packed {
		logic [7:0]  lim0;
		logic [7:0]  lim1;
		logic [7:0]  lim2;
		logic [15:0] period;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/mfq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/mfq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mfq_front
	import mfq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] opcode,
	input  wire logic [5:0] slot,
	input  wire logic [7:0] quanta_used,
	input  wire logic       still_runnable,
	input  wire logic       new_mode,
	input  wire logic [3:0] priority_value,
	output logic            item_valid,
	output item_t           item,
	input  wire logic       item_take
);

	item_t      buf_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;
	item_t      cls;

	// classify the incoming beat
	always_comb begin
		cls.op             = op_t'(opcode);
		cls.slot           = slot;
		cls.quanta_used    = quanta_used;
		cls.still_runnable = still_runnable;
		cls.new_mode       = new_mode;
		cls.priority_value = priority_value;
	end

	assign in_stall   = (cnt_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign item_valid = (cnt_q != 2'd0);
	assign pop        = item_valid && item_take;
	assign item       = buf_q[rd_q];

	// hold payload of queued items
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= cls;
		end
	end

	// advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/mfq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mfq_back
	import mfq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       item_valid,
	input  wire item_t      item,
	output logic            item_take,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            picked_valid,
	output logic [5:0]      picked_slot,
	output logic [1:0]      picked_level,
	output logic [1:0]      status
);

	typedef enum logic [2:0] {
		S_IDLE, S_SLOT, S_WALK_RD, S_WALK_CHK, S_POP, S_POP_W, S_POP_C
	} state_t;

	state_t             state_q;
	item_t              item_q;
	logic               mode_q;
	logic [31:0]        tick_q, last_q;
	logic [SLOT_W-1:0]  head_q [RING_CNT];
	logic [SLOT_W-1:0]  tail_q [RING_CNT];
	logic [NUM_SLOTS-1:0] svld_q;
	logic               rd_vld_q;
	logic [SLOT_W-1:0]  walk_q;
	logic               walk_pop_q;
	logic               full_q;
	logic [LVL_W-1:0]   lv_q;

	// slot table ports
	logic               s_we;
	logic [SLOT_W-1:0]  s_waddr, s_raddr;
	slot_info_t         s_wdata, s_rdata, cur, nxt;

	// ring store ports
	logic               r_we;
	logic [RADDR_W-1:0] r_waddr, r_raddr;
	logic [SLOT_W-1:0]  r_rdata;

	logic               push_req, push_full;
	logic [RING_W-1:0]  push_ring, pop_ring;
	logic [SLOT_W-1:0]  push_slot;
	logic [8:0]         qsum;
	logic [7:0]         qsat;
	logic               boost_due;

	mfq_ram #(.WIDTH($bits(slot_info_t)), .DEPTH(NUM_SLOTS)) u_slot_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	mfq_ram #(.WIDTH(SLOT_W), .DEPTH(RING_CNT * NUM_SLOTS)) u_ring_ram (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(push_slot),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	assign item_take = (state_q == S_IDLE) && item_valid && !out_valid;
	assign cur       = rd_vld_q ? s_rdata : '0;
	assign qsum      = {1'b0, cur.quanta} + {1'b0, item_q.quanta_used};
	assign qsat      = qsum[8] ? 8'hFF : qsum[7:0];
	assign boost_due = (tick_q - last_q) >= {16'd0, cfg.period};
	assign pop_ring  = mode_q ? (RING_W'(lv_q) + RING_W'(1)) : RING_W'(0);

	// read address selection
	always_comb begin
		unique case (state_q)
			S_IDLE:    s_raddr = item.slot[SLOT_W-1:0];
			S_WALK_RD: s_raddr = walk_q;
			S_POP_W:   s_raddr = r_rdata;
			default:   s_raddr = item_q.slot[SLOT_W-1:0];
		endcase
		r_raddr = {pop_ring, head_q[pop_ring]};
	end

	// decide slot update and ring push
	always_comb begin
		nxt       = cur;
		s_we      = 1'b0;
		s_waddr   = item_q.slot[SLOT_W-1:0];
		push_req  = 1'b0;
		push_slot = item_q.slot[SLOT_W-1:0];
		unique case (state_q)
			S_SLOT: begin
				case (item_q.op)
					OP_READY: begin
						if (cur.status == ST_IDLE || cur.status == ST_BLOCKED) begin
							if (cur.status == ST_IDLE) begin
								nxt.level  = '0;
								nxt.quanta = '0;
								nxt.prio   = mode_q ? PRIO_TOP : 2'd0;
							end
							nxt.status = ST_READY;
							s_we       = 1'b1;
							push_req   = 1'b1;
						end
					end
					OP_BLOCK: begin
						if (cur.status != ST_IDLE) begin
							nxt.status = ST_BLOCKED;
							s_we       = 1'b1;
						end
					end
					OP_RUNDONE: begin
						if (cur.status == ST_RUN) begin
							s_we       = 1'b1;
							nxt.quanta = qsat;
							if (!item_q.still_runnable) begin
								nxt.status = ST_BLOCKED;
							end else begin
								nxt.status = ST_READY;
								push_req   = 1'b1;
								if (mode_q) begin
									if (32'(cur.level) + 32'd1 >= 32'(NUM_LEVELS)) begin
										if (qsat >= cfg.lim2) begin
											nxt.quanta = '0;
											if (cur.prio != 2'd0) nxt.prio = cur.prio - 2'd1;
										end
									end else if (qsat >= ((cur.level == '0) ? cfg.lim0 : cfg.lim1)) begin
										nxt.level  = cur.level + LVL_W'(1);
										nxt.quanta = '0;
									end
								end
							end
						end
					end
					OP_SETPRIO: begin
						if (item_q.priority_value <= 4'd3) begin
							nxt.prio = item_q.priority_value[1:0];
							s_we     = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_WALK_CHK: begin
				s_waddr   = walk_q;
				push_slot = walk_q;
				if (cur.status == ST_READY || cur.status == ST_RUN) begin
					nxt.status = ST_READY;
					nxt.level  = '0;
					nxt.quanta = '0;
					nxt.prio   = mode_q ? PRIO_TOP : 2'd0;
					s_we       = 1'b1;
					push_req   = 1'b1;
				end
			end
			S_POP_C: begin
				s_waddr = push_slot;
				s_waddr = item_q.slot[SLOT_W-1:0];
				if (cur.status == ST_READY) begin
					nxt.status = ST_RUN;
					s_we       = 1'b1;
				end
			end
			default: ;
		endcase
		s_wdata   = nxt;
		push_ring = mode_q ? (RING_W'(nxt.level) + RING_W'(1)) : RING_W'(0);
		push_full = (tail_q[push_ring] + SLOT_W'(1)) == head_q[push_ring];
		r_we      = push_req && !push_full;
		r_waddr   = {push_ring, tail_q[push_ring]};
	end

	// sequence each item and hold the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			item_q       <= '0;
			mode_q       <= 1'b0;
			tick_q       <= '0;
			last_q       <= '0;
			svld_q       <= '0;
			rd_vld_q     <= 1'b0;
			walk_q       <= '0;
			walk_pop_q   <= 1'b0;
			full_q       <= 1'b0;
			lv_q         <= '0;
			out_valid    <= 1'b0;
			picked_valid <= 1'b0;
			picked_slot  <= '0;
			picked_level <= '0;
			status       <= RES_OK;
			for (int i = 0; i < RING_CNT; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			rd_vld_q <= svld_q[s_raddr];
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (s_we) svld_q[s_waddr] <= 1'b1;
			if (r_we) tail_q[push_ring] <= tail_q[push_ring] + SLOT_W'(1);
			unique case (state_q)
				S_IDLE: begin
					if (item_take) begin
						item_q       <= item;
						full_q       <= 1'b0;
						lv_q         <= '0;
						picked_valid <= 1'b0;
						picked_slot  <= '0;
						picked_level <= '0;
						case (item.op)
							OP_READY, OP_BLOCK, OP_RUNDONE: begin
								state_q <= S_SLOT;
							end
							OP_SETPRIO: begin
								if (item.priority_value > 4'd3) begin
									status    <= RES_BADPRIO;
									out_valid <= 1'b1;
								end else begin
									state_q <= S_SLOT;
								end
							end
							OP_DISPATCH: begin
								if (mode_q && boost_due) begin
									last_q     <= tick_q;
									walk_q     <= '0;
									walk_pop_q <= 1'b1;
									state_q    <= S_WALK_RD;
									for (int i = 0; i < RING_CNT; i++) begin
										head_q[i] <= '0;
										tail_q[i] <= '0;
									end
								end else begin
									state_q <= S_POP;
								end
							end
							OP_TICK: begin
								tick_q    <= tick_q + 32'd1;
								status    <= RES_OK;
								out_valid <= 1'b1;
							end
							OP_MODE: begin
								if (item.new_mode == mode_q) begin
									status    <= RES_SAMEMODE;
									out_valid <= 1'b1;
								end else begin
									mode_q     <= item.new_mode;
									tick_q     <= '0;
									walk_q     <= '0;
									walk_pop_q <= 1'b0;
									state_q    <= S_WALK_RD;
									for (int i = 0; i < RING_CNT; i++) begin
										head_q[i] <= '0;
										tail_q[i] <= '0;
									end
								end
							end
							default: begin
								status    <= RES_OK;
								out_valid <= 1'b1;
							end
						endcase
					end
				end
				S_SLOT: begin
					status    <= (push_req && push_full) ? RES_FULL : RES_OK;
					out_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				S_WALK_RD: begin
					state_q <= S_WALK_CHK;
				end
				S_WALK_CHK: begin
					if (push_req && push_full) full_q <= 1'b1;
					if (walk_q == SLOT_W'(NUM_SLOTS - 1)) begin
						if (walk_pop_q) begin
							state_q <= S_POP;
						end else begin
							status    <= (full_q || (push_req && push_full)) ? RES_FULL : RES_OK;
							out_valid <= 1'b1;
							state_q   <= S_IDLE;
						end
					end else begin
						walk_q  <= walk_q + SLOT_W'(1);
						state_q <= S_WALK_RD;
					end
				end
				S_POP: begin
					if (head_q[pop_ring] == tail_q[pop_ring]) begin
						if (mode_q && (32'(lv_q) + 32'd1 < 32'(NUM_LEVELS))) begin
							lv_q <= lv_q + LVL_W'(1);
						end else begin
							status    <= full_q ? RES_FULL : RES_OK;
							out_valid <= 1'b1;
							state_q   <= S_IDLE;
						end
					end else begin
						head_q[pop_ring] <= head_q[pop_ring] + SLOT_W'(1);
						state_q          <= S_POP_W;
					end
				end
				S_POP_W: begin
					item_q.slot <= 6'(r_rdata);
					state_q     <= S_POP_C;
				end
				S_POP_C: begin
					if (cur.status == ST_READY) begin
						picked_valid <= 1'b1;
						picked_slot  <= item_q.slot;
						picked_level <= mode_q ? cur.level : LEVEL_FCFS;
						status       <= full_q ? RES_FULL : RES_OK;
						out_valid    <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_POP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// first-come picks always report the first-come level
	a_fcfs_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && picked_valid && !mode_q |-> picked_level == LEVEL_FCFS)
		else $error("first-come pick with wrong level");

	// a miss reports no slot and no level
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !picked_valid |-> picked_slot == '0 && picked_level == '0)
		else $error("miss carries slot or level");

	// requeue pushes go to level zero or the first-come ring only
	a_walk_ring: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK_CHK && r_we |-> push_ring == (mode_q ? RING_W'(1) : RING_W'(0)))
		else $error("requeue pushed to a lower level");

	// no new item starts while a result beat waits
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(picked_slot) && $stable(status))
		else $error("result beat overwritten");

endmodule
`default_nettype wire

// ===== rtl/core/mlfq_fcfs_ready_scheduler_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Ready-queue scheduler for 64 task slots with a first-come ring and three
// feedback level rings. Each event gives one result beat. Ready, block, run
// done and set priority take one slot table read, then an update, with a ring
// push for ready and run done; tick and rejected events answer without a slot
// read. A dispatch pops ring entries with a ring read, a slot read and a check
// each, and steps past empty levels. A mode switch, and a dispatch that
// triggers a boost, walk the whole slot table, reading and checking each slot.
// Events queue two deep ahead of the sequencer, so input beats are taken while
// a result waits. Set registers through the APB port only while the block is idle.
module mlfq_fcfs_ready_scheduler_top
	import mfq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  opcode,
	input  wire logic [5:0]  slot,
	input  wire logic [7:0]  quanta_used,
	input  wire logic        still_runnable,
	input  wire logic        new_mode,
	input  wire logic [3:0]  priority_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             picked_valid,
	output logic [5:0]       picked_slot,
	output logic [1:0]       picked_level,
	output logic [1:0]       status
);

	cfg_t  cfg_q;
	logic  item_valid, item_take;
	item_t item;

	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lim0   <= 8'd1;
			cfg_q.lim1   <= 8'd3;
			cfg_q.lim2   <= 8'd5;
			cfg_q.period <= 16'd50;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_LIM0:   cfg_q.lim0   <= pwdata[7:0];
				REG_LIM1:   cfg_q.lim1   <= pwdata[7:0];
				REG_LIM2:   cfg_q.lim2   <= pwdata[7:0];
				REG_PERIOD: cfg_q.period <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (paddr[3:2])
			REG_LIM0:   prdata = {24'd0, cfg_q.lim0};
			REG_LIM1:   prdata = {24'd0, cfg_q.lim1};
			REG_LIM2:   prdata = {24'd0, cfg_q.lim2};
			REG_PERIOD: prdata = {16'd0, cfg_q.period};
			default:    prdata = '0;
		endcase
	end

	mfq_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .slot(slot), .quanta_used(quanta_used),
		.still_runnable(still_runnable), .new_mode(new_mode),
		.priority_value(priority_value),
		.item_valid(item_valid), .item(item), .item_take(item_take)
	);

	mfq_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.item_valid(item_valid), .item(item), .item_take(item_take),
		.out_valid(out_valid), .out_stall(out_stall),
		.picked_valid(picked_valid), .picked_slot(picked_slot),
		.picked_level(picked_level), .status(status)
	);

endmodule
`default_nettype wire

// ===== test/tb_mlfq_fcfs_ready_scheduler_top.sv =====
`timescale 1ns / 1ps
module tb_mlfq_fcfs_ready_scheduler_top;
	import mfq_pkg::*;

	typedef struct packed {
		logic       pv;
		logic [5:0] ps;
		logic [1:0] pl;
		logic [1:0] st;
	} pick_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] slot;
		logic [7:0] quanta;
		logic       keep;
		logic       mode;
		logic [3:0] prio;
		logic       typed;
		pick_t      res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  opcode = '0;
	logic [5:0]  slot = '0;
	logic [7:0]  quanta_used = '0;
	logic        still_runnable = 1'b0;
	logic        new_mode = 1'b0;
	logic [3:0]  priority_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic        picked_valid;
	logic [5:0]  picked_slot;
	logic [1:0]  picked_level;
	logic [1:0]  status;

	// scheduler mirror
	logic [5:0]  ring_mem [RING_CNT][NUM_SLOTS];
	int          ring_head [RING_CNT];
	int          ring_tail [RING_CNT];
	logic [1:0]  slot_st [NUM_SLOTS];
	logic [1:0]  slot_lvl [NUM_SLOTS];
	logic [1:0]  slot_pri [NUM_SLOTS];
	logic [7:0]  slot_q [NUM_SLOTS];
	logic        fb_mode;
	logic [31:0] ticks, boost_mark;
	cfg_t        cfg;

	pick_t       pending_picks [$];
	int          mismatches = 0;
	bit          no_idle = 1'b0;

	always #4 clk = ~clk;

	mlfq_fcfs_ready_scheduler_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .slot(slot), .quanta_used(quanta_used),
		.still_runnable(still_runnable), .new_mode(new_mode),
		.priority_value(priority_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.picked_valid(picked_valid), .picked_slot(picked_slot),
		.picked_level(picked_level), .status(status)
	);

	function automatic bit ring_put(int r, int s);
		int nxt;
		nxt = (ring_tail[r] + 1) % NUM_SLOTS;
		if (nxt == ring_head[r]) return 1'b0;
		ring_mem[r][ring_tail[r]] = s[5:0];
		ring_tail[r] = nxt;
		return 1'b1;
	endfunction

	function automatic bit ring_take(int r, output int s);
		s = 0;
		if (ring_head[r] == ring_tail[r]) return 1'b0;
		s = ring_mem[r][ring_head[r]];
		ring_head[r] = (ring_head[r] + 1) % NUM_SLOTS;
		return 1'b1;
	endfunction

	function automatic int home_of(int s);
		return fb_mode ? 1 + slot_lvl[s] : 0;
	endfunction

	// drop all rings and requeue every live slot at level 0
	function automatic bit requeue_live();
		bit full;
		full = 1'b0;
		for (int r = 0; r < RING_CNT; r++) begin
			ring_head[r] = 0;
			ring_tail[r] = 0;
		end
		for (int s = 0; s < NUM_SLOTS; s++) begin
			if (slot_st[s] == ST_READY || slot_st[s] == ST_RUN) begin
				slot_st[s] = ST_READY;
				slot_lvl[s] = '0;
				slot_q[s] = '0;
				slot_pri[s] = fb_mode ? PRIO_TOP : 2'd0;
				if (!ring_put(home_of(s), s)) full = 1'b1;
			end
		end
		return full;
	endfunction

	function automatic pick_t schedule_event(item_t it);
		pick_t r;
		int s, cand, sum;
		bit found;
		r = '0;
		s = it.slot;
		found = 1'b0;
		cand = 0;
		case (it.op)
			OP_READY: begin
				if (slot_st[s] == ST_IDLE || slot_st[s] == ST_BLOCKED) begin
					if (slot_st[s] == ST_IDLE) begin
						slot_lvl[s] = '0;
						slot_q[s] = '0;
						slot_pri[s] = fb_mode ? PRIO_TOP : 2'd0;
					end
					slot_st[s] = ST_READY;
					if (!ring_put(home_of(s), s)) r.st = RES_FULL;
				end
			end
			OP_BLOCK: if (slot_st[s] != ST_IDLE) slot_st[s] = ST_BLOCKED;
			OP_DISPATCH: begin
				if (fb_mode) begin
					if (ticks - boost_mark >= {16'd0, cfg.period}) begin
						boost_mark = ticks;
						if (requeue_live()) r.st = RES_FULL;
					end
					for (int lv = 0; lv < NUM_LEVELS && !found; lv++)
						while (!found && ring_take(1 + lv, cand))
							if (slot_st[cand] == ST_READY) found = 1'b1;
				end else begin
					while (!found && ring_take(0, cand))
						if (slot_st[cand] == ST_READY) found = 1'b1;
				end
				if (found) begin
					slot_st[cand] = ST_RUN;
					r.pv = 1'b1;
					r.ps = cand[5:0];
					r.pl = fb_mode ? slot_lvl[cand] : LEVEL_FCFS;
				end
			end
			OP_RUNDONE: begin
				if (slot_st[s] == ST_RUN) begin
					sum = slot_q[s] + it.quanta_used;
					slot_q[s] = sum > 255 ? 8'd255 : sum[7:0];
					if (!it.still_runnable) begin
						slot_st[s] = ST_BLOCKED;
					end else begin
						slot_st[s] = ST_READY;
						if (fb_mode) begin
							if (slot_lvl[s] + 1 >= NUM_LEVELS) begin
								if (slot_q[s] >= cfg.lim2) begin
									slot_q[s] = '0;
									if (slot_pri[s] > 0) slot_pri[s]--;
								end
							end else if (slot_q[s] >= (slot_lvl[s] == 0 ? cfg.lim0 : cfg.lim1)) begin
								slot_lvl[s]++;
								slot_q[s] = '0;
							end
						end
						if (!ring_put(home_of(s), s)) r.st = RES_FULL;
					end
				end
			end
			OP_TICK: ticks++;
			OP_MODE: begin
				if (it.new_mode == fb_mode) begin
					r.st = RES_SAMEMODE;
				end else begin
					fb_mode = it.new_mode;
					ticks = '0;
					if (requeue_live()) r.st = RES_FULL;
				end
			end
			OP_SETPRIO: begin
				if (it.priority_value > 3) r.st = RES_BADPRIO;
				else slot_pri[s] = it.priority_value[1:0];
			end
			default: ;
		endcase
		return r;
	endfunction

	// drive one event beat; valid stays high when the next beat has no gap
	task automatic send_event(item_t it, bit typed, pick_t typed_res);
		int gap;
		pick_t p;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode = it.op;
		slot = it.slot;
		quanta_used = it.quanta_used;
		still_runnable = it.still_runnable;
		new_mode = it.new_mode;
		priority_value = it.priority_value;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		p = schedule_event(it);
		pending_picks.push_back(typed ? typed_res : p);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending_picks.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [31:0] val);
		paddr = {idx, 2'b00};
		pwdata = val;
		pwrite = 1'b1;
		psel = 1'b1;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_LIM0: cfg.lim0 = val[7:0];
			REG_LIM1: cfg.lim1 = val[7:0];
			REG_LIM2: cfg.lim2 = val[7:0];
			default:  cfg.period = val[15:0];
		endcase
	endtask

	function automatic item_t noise_fields();
		item_t it;
		it = $bits(item_t)'($urandom);
		case ($urandom_range(0, 3))
			0: it.quanta_used = 8'($urandom);
			1: it.quanta_used = 8'd255;
			default: it.quanta_used = 8'($urandom_range(0, 6));
		endcase
		it.priority_value = ($urandom_range(0, 3) == 0) ? 4'($urandom) :
			4'($urandom_range(0, 3));
		return it;
	endfunction

	// mostly a few slots with live traffic, run done aimed at running slots
	function automatic item_t random_event();
		item_t it;
		int w, running [$];
		it = noise_fields();
		it.slot = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
		w = $urandom_range(0, 99);
		if (w < 20) it.op = OP_READY;
		else if (w < 28) it.op = OP_BLOCK;
		else if (w < 53) it.op = OP_DISPATCH;
		else if (w < 73) it.op = OP_RUNDONE;
		else if (w < 85) it.op = OP_TICK;
		else if (w < 89) it.op = OP_MODE;
		else if (w < 95) it.op = OP_SETPRIO;
		else it.op = op_t'($urandom_range(0, 7));
		if (it.op == OP_RUNDONE && $urandom_range(0, 9) != 0) begin
			for (int s = 0; s < NUM_SLOTS; s++)
				if (slot_st[s] == ST_RUN) running.push_back(s);
			if (running.size() != 0)
				it.slot = 6'(running[$urandom_range(0, running.size() - 1)]);
		end
		return it;
	endfunction

	// check result beats against the oldest expectation
	always @(posedge clk) begin
		pick_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_picks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: valid %0d slot %0d level %0d status %0d",
						picked_valid, picked_slot, picked_level, status);
			end else begin
				want = pending_picks.pop_front();
				if (want.pv !== picked_valid || want.ps !== picked_slot ||
						want.pl !== picked_level || want.st !== status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected valid %0d slot %0d level %0d status %0d, got %0d %0d %0d %0d",
							$realtime, want.pv, want.ps, want.pl, want.st,
							picked_valid, picked_slot, picked_level, status);
				end
			end
		end
	end

	// hold off result beats for a random number of cycles each
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 12);
			@(negedge clk);
			out_stall = 1'b1;
			repeat (n) @(negedge clk);
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#50_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		dir_row_t dir_rows [0:22];
		item_t it;
		logic [31:0] limits [5][4];

		dir_rows = '{
			'{OP_MODE,     6'd0,  8'd0,   1'b0, 1'b0, 4'd0,  1'b1, '{1'b0, 6'd0, 2'd0, RES_SAMEMODE}},
			'{OP_SETPRIO,  6'd63, 8'd0,   1'b0, 1'b0, 4'd15, 1'b1, '{1'b0, 6'd0, 2'd0, RES_BADPRIO}},
			'{OP_DISPATCH, 6'd0,  8'd0,   1'b0, 1'b0, 4'd0,  1'b1, '{1'b0, 6'd0, 2'd0, RES_OK}},
			'{OP_RUNDONE,  6'd0,  8'd9,   1'b1, 1'b0, 4'd0,  1'b1, '{1'b0, 6'd0, 2'd0, RES_OK}},
			'{OP_READY,    6'd63, 8'd0,   1'b0, 1'b0, 4'd0,  1'b1, '{1'b0, 6'd0, 2'd0, RES_OK}},
			'{OP_READY,    6'd0,  8'd0,   1'b0, 1'b0, 4'd0,  1'b1, '{1'b0, 6'd0, 2'd0, RES_OK}},
			'{OP_READY,    6'd0,  8'd0,   1'b0, 1'b0, 4'd0,  1'b0, '0},
			'{OP_DISPATCH, 6'd0,  8'd0,   1'b0, 1'b0, 4'd0,  1'b1, '{1'b1, 6'd63, LEVEL_FCFS, RES_OK}},
			'{OP_RUNDONE,  6'd63, 8'd255, 1'b1, 1'b0, 4'd0,  1'b0, '0},
			'{OP_BLOCK,    6'd0,  8'd0,   1'b0, 1'b0, 4'd0,  1'b0, '0},
			'{OP_DISPATCH, 6'd0,  8'd0,   1'b0, 1'b0, 4'd0,  1'b0, '0},
			'{OP_BLOCK,    6'd42, 8'd0,   1'b0, 1'b0, 4'd0,  1'b0, '0},
			'{OP_SETPRIO,  6'd63, 8'd0,   1'b0, 1'b0, 4'd3,  1'b0, '0},
			'{OP_MODE,     6'd0,  8'd0,   1'b0, 1'b1, 4'd0,  1'b0, '0},
			'{OP_TICK,     6'd0,  8'd0,   1'b0, 1'b0, 4'd0,  1'b0, '0},
			'{OP_DISPATCH, 6'd0,  8'd0,   1'b0, 1'b0, 4'd0,  1'b0, '0},
			'{OP_RUNDONE,  6'd63, 8'd255, 1'b1, 1'b0, 4'd0,  1'b0, '0},
			'{OP_READY,    6'd0,  8'd0,   1'b0, 1'b0, 4'd0,  1'b0, '0},
			'{OP_DISPATCH, 6'd0,  8'd0,   1'b0, 1'b0, 4'd0,  1'b0, '0},
			'{OP_RUNDONE,  6'd63, 8'd1,   1'b0, 1'b0, 4'd0,  1'b0, '0},
			'{OP_NOP,      6'd21, 8'hAA,  1'b1, 1'b1, 4'd10, 1'b1, '{1'b0, 6'd0, 2'd0, RES_OK}},
			'{OP_MODE,     6'd0,  8'd0,   1'b0, 1'b0, 4'd0,  1'b0, '0},
			'{OP_SETPRIO,  6'd1,  8'd0,   1'b0, 1'b0, 4'd8,  1'b1, '{1'b0, 6'd0, 2'd0, RES_BADPRIO}}
		};
		limits = '{
			'{32'd0,   32'd0,   32'd0,   32'd1},
			'{32'd255, 32'd255, 32'd255, 32'd65535},
			'{32'd2,   32'd1,   32'd4,   32'd7},
			'{32'd1,   32'd3,   32'd5,   32'd50},
			'{32'd0,   32'd2,   32'd1,   32'd3}
		};

		// mirror reset
		for (int r = 0; r < RING_CNT; r++) begin
			ring_head[r] = 0;
			ring_tail[r] = 0;
		end
		for (int s = 0; s < NUM_SLOTS; s++) begin
			slot_st[s] = ST_IDLE;
			slot_lvl[s] = '0;
			slot_pri[s] = '0;
			slot_q[s] = '0;
		end
		fb_mode = 1'b0;
		ticks = '0;
		boost_mark = '0;
		cfg = '{lim0: 8'd1, lim1: 8'd3, lim2: 8'd5, period: 16'd50};

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed events
		foreach (dir_rows[i]) begin
			it = '{dir_rows[i].op, dir_rows[i].slot, dir_rows[i].quanta, dir_rows[i].keep,
				dir_rows[i].mode, dir_rows[i].prio};
			send_event(it, dir_rows[i].typed, dir_rows[i].res);
		end
		drain();

		// random traffic under several limit settings, with and without idling
		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0)
				for (int k = 0; k < 4; k++)
					apb_write(k[1:0], ph == 5 ? {24'd0, 8'($urandom)} |
						(k == 3 ? {16'd0, 16'($urandom_range(1, 65535))} : 32'd0) :
						limits[ph - 1][k]);
			no_idle = (ph == 2);
			repeat (150) send_event(random_event(), 1'b0, '0);
			drain();
		end

		// churn one slot through ready and block, piling its entries up in the first-come ring
		no_idle = 1'b0;
		it = noise_fields();
		it.op = OP_MODE;
		it.new_mode = 1'b0;
		send_event(it, 1'b0, '0);
		for (int k = 0; k < 70; k++) begin
			it = noise_fields();
			it.op = (k % 2 == 0) ? OP_READY : OP_BLOCK;
			it.slot = 6'd9;
			send_event(it, 1'b0, '0);
		end
		// every slot live, then a mode switch that cannot requeue them all
		for (int s = 0; s < NUM_SLOTS; s++) begin
			it = noise_fields();
			it.op = OP_READY;
			it.slot = s[5:0];
			send_event(it, 1'b0, '0);
		end
		it = noise_fields();
		it.op = OP_MODE;
		it.new_mode = 1'b1;
		send_event(it, 1'b0, '0);
		repeat (40) send_event(random_event(), 1'b0, '0);
		drain();

		if (mismatches == 0 && pending_picks.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/mfq_pkg.sv
rtl/core/mfq_ram.sv
rtl/core/mfq_front.sv
rtl/core/mfq_back.sv
rtl/core/mlfq_fcfs_ready_scheduler_top.sv
test/tb_mlfq_fcfs_ready_scheduler_top.sv
